/* rtl/pcs_pkg.sv */
// shared constants and types for the priority scheduler
`default_nettype none
package pcs_pkg;
  localparam int MaxProcs = 16;
  localparam int SlotW = $clog2(MaxProcs);
  localparam int CountW = $clog2(MaxProcs + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // per-slot entry held in a cell
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic        started;
  } entry_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic [SlotW-1:0]  load_slot;
    logic              dec;
    logic [SlotW-1:0]  dec_slot;
    logic              mark;
  } cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/pcs_cell.sv */
// one table slot: holds its entry and shifts a view of it into the scan chain
`default_nettype none
module pcs_cell import pcs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [SlotW-1:0] slot_id,
  input  wire cell_ctl_t        ctl,
  input  wire entry_t           load_val,
  input  wire logic             shift,
  input  wire entry_t           chain_in,
  output entry_t                chain_out
);
  entry_t ent_r;
  entry_t view_r;

  // own entry: load, decrement, start mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.started <= 1'b0;
    end else if (ctl.load && ctl.load_slot == slot_id) begin
      ent_r <= load_val;
    end else if (ctl.dec && ctl.dec_slot == slot_id) begin
      ent_r.remaining <= ent_r.remaining - 16'd1;
      if (ctl.mark) ent_r.started <= 1'b1;
    end
  end

  // scan view: loads own entry, then hands neighbor's along
  always_ff @(posedge clk) begin
    if (shift) view_r <= chain_in;
    else       view_r <= ent_r;
  end

  assign chain_out = view_r;
endmodule
`default_nettype wire

/* rtl/priority_cpu_scheduler_top.sv */
// top level of the priority scheduler: sequencer plus a chain of slot cells
//
// Input channel: start with in_opcode and process fields; accepted when
// start is high and busy is low. A load beat writes the next free slot
// (ignored when the table is full) and gives no result.
// A tick beat gives one result: out_valid pulses for one cycle with
// out_run_slot, out_idle, out_all_done, out_total_wait, out_loaded_count.
// A tick steps through the states: S_SNAP snapshots the cells, S_SCAN
// shifts slot views out of the cell chain into the compare unit, S_COMMIT
// commits, and the result is then presented. Busy is high in S_SNAP,
// S_SCAN and S_COMMIT, so the next beat is taken as the result shows.
// Configuration: cfg_valid/cfg_ready write cfg_data as preemptive mode;
// cfg_ready is always high; write only while idle.
// Reset (rst_n low, synchronous) empties the table, zeroes time and wait.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module priority_cpu_scheduler_top import pcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [15:0] in_proc_arrival,
  input  wire logic [15:0] in_proc_burst,
  input  wire logic [7:0]  in_proc_priority,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  output logic             out_valid,
  output logic [3:0]       out_run_slot,
  output logic             out_idle,
  output logic             out_all_done,
  output logic [31:0]      out_total_wait,
  output logic [4:0]       out_loaded_count
);
  typedef enum logic [1:0] {S_IDLE, S_SNAP, S_SCAN, S_COMMIT} state_t;

  state_t             state_r;
  logic               mode_r;
  logic [CountW-1:0]  count_r;
  logic [31:0]        time_r, wait_r;
  logic [SlotW-1:0]   cur_r;
  logic               cur_busy_r;
  logic [CountW-1:0]  scan_r;
  logic               found_r, hold_ok_r, not_done_r;
  logic [SlotW-1:0]   best_r;
  entry_t             best_e_r;
  logic [SlotW:0]     elig_r;
  cell_ctl_t          ctl;
  entry_t             load_val;
  entry_t             chain [MaxProcs+1];
  logic               shift;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != S_IDLE);
  assign load_val = '{arrival: in_proc_arrival, remaining: in_proc_burst,
                      prio: in_proc_priority, started: 1'b0};
  assign chain[MaxProcs] = '0;
  assign shift = (state_r == S_SCAN);

  // row of cells; cell 0 feeds the compare unit, so slots arrive in order
  for (genvar g = 0; g < MaxProcs; g++) begin : g_cell
    pcs_cell u_cell (
      .clk, .rst_n, .slot_id(SlotW'(g)), .ctl, .load_val, .shift,
      .chain_in(chain[g+1]), .chain_out(chain[g])
    );
  end

  // scanned slot view
  entry_t            sv;
  logic [SlotW-1:0]  sidx;
  logic              in_tab, elig, better;
  assign sv     = chain[0];
  assign sidx   = scan_r[SlotW-1:0];
  assign in_tab = scan_r < count_r;
  assign elig   = in_tab && ({16'd0, sv.arrival} <= time_r) && (sv.remaining != 16'd0);
  assign better = !found_r || (sv.prio < best_e_r.prio) ||
                  (sv.prio == best_e_r.prio && sv.arrival < best_e_r.arrival);

  // commit decisions
  logic              hold, ran, add_start;
  logic [SlotW-1:0]  run_slot;
  entry_t            run_e;
  logic [32:0]       wsum;
  logic [31:0]       add_amt;
  logic [SlotW:0]    others;
  always_comb begin
    hold     = !mode_r && cur_busy_r && hold_ok_r;
    ran      = hold || found_r;
    run_slot = hold ? cur_r : best_r;
    run_e    = best_e_r;
    add_start = !mode_r && !hold && found_r && !run_e.started;
    others   = (found_r && mode_r) ? elig_r - 1'b1 : '0;
    if (add_start) add_amt = time_r - {16'd0, run_e.arrival};
    else           add_amt = {{(32-SlotW-1){1'b0}}, others};
    wsum = {1'b0, wait_r} + {1'b0, add_amt};
    ctl = '0;
    ctl.load      = (state_r == S_IDLE) && start && (in_opcode == OP_LOAD) &&
                    (count_r < CountW'(MaxProcs));
    ctl.load_slot = count_r[SlotW-1:0];
    ctl.dec       = (state_r == S_COMMIT) && ran;
    ctl.dec_slot  = run_slot;
    ctl.mark      = 1'b1;
  end

  // track whether the run slot ends and was the only unfinished one
  logic rem_one, single_left, all_done;
  logic [SlotW:0] undone_r;
  logic [15:0]    cur_rem_r;
  always_ff @(posedge clk) begin
    if (state_r == S_SNAP) undone_r <= '0;
    else if (state_r == S_SCAN && in_tab && sv.remaining != 16'd0) begin
      undone_r <= undone_r + 1'b1;
      if (sidx == cur_r) cur_rem_r <= sv.remaining;
    end
  end
  assign rem_one     = hold ? (cur_rem_r == 16'd1) : (best_e_r.remaining == 16'd1);
  assign single_left = (undone_r == (SlotW+1)'(1));
  // all_done after the decrement: only one slot changes by one
  assign all_done    = !not_done_r || (ran && rem_one && single_left);

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mode_r <= 1'b0; count_r <= '0; time_r <= '0;
      wait_r <= '0; cur_r <= '0; cur_busy_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid) mode_r <= cfg_data;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_opcode == OP_TICK) state_r <= S_SNAP;
            else if (ctl.load) count_r <= count_r + 1'b1;
          end
        end
        S_SNAP: begin
          state_r <= S_SCAN; scan_r <= '0; found_r <= 1'b0; elig_r <= '0;
          hold_ok_r <= 1'b0; not_done_r <= 1'b0; best_r <= '0;
        end
        S_SCAN: begin
          if (in_tab && sv.remaining != 16'd0) begin
            not_done_r <= 1'b1;
            if (sidx == cur_r) hold_ok_r <= 1'b1;
          end
          if (elig) begin
            elig_r <= elig_r + 1'b1;
            if (better) begin
              found_r <= 1'b1; best_r <= sidx; best_e_r <= sv;
            end
          end
          if (scan_r == CountW'(MaxProcs - 1)) state_r <= S_COMMIT;
          scan_r <= scan_r + 1'b1;
        end
        S_COMMIT: begin
          state_r <= S_IDLE;
          if (mode_r) cur_busy_r <= 1'b0;
          if (ran) begin
            wait_r <= wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
            if (!mode_r) begin
              cur_r <= run_slot;
              // remaining before decrement; held slot remaining unknown here
              cur_busy_r <= 1'b1;
            end
          end else if (!mode_r) begin
            cur_busy_r <= 1'b0;
          end
          if (time_r != 32'hFFFF_FFFF) time_r <= time_r + 32'd1;
          out_valid        <= 1'b1;
          out_run_slot     <= ran ? 4'(run_slot) : 4'd0;
          out_idle         <= !ran;
          out_loaded_count <= 5'(count_r);
          out_all_done     <= all_done;
          out_total_wait   <= (ran) ? (wsum[32] ? 32'hFFFF_FFFF : wsum[31:0]) : wait_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
